// ----- rtl/camera_path_bezier_interpolator_defines.svh -----
// Assertion macros shared by the camera path interpolator RTL.
// Expects clk and rst_n to be in scope where a macro is used.
`ifndef CAMERA_PATH_BEZIER_INTERPOLATOR_DEFINES_SVH
`define CAMERA_PATH_BEZIER_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define CPBI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpbi_pkg.sv -----
// Package for the camera path interpolator: fixed-point constants,
// register indexes and reset values. No dependencies.
package cpbi_pkg;

  localparam int unsigned T_W = 17;
  localparam logic [T_W-1:0] ONE_Q16 = 17'd65536;

  typedef logic [T_W-1:0] q16_t;   // Q1.16 value, 0..1.0 inclusive
  typedef logic [32:0]    wgt_t;   // Bezier basis weight, Q1.32 up to 1.0

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_START_POINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_POINT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_ANGLES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_FOV    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_FOV      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = 3'd7;

  localparam logic [7:0] FOV_RESET = 8'd90;

  localparam logic [1:0] SMOOTH_NONE = 2'd0;
  localparam logic [1:0] SMOOTH_IN   = 2'd1;
  localparam logic [1:0] SMOOTH_OUT  = 2'd2;
  localparam logic [1:0] SMOOTH_BOTH = 2'd3;

endpackage

// ----- rtl/cpbi_in_if.sv -----
// Request channel carrying the path parameter t.
// Depends on cpbi_pkg for the parameter type.
interface cpbi_in_if;
  logic          valid;
  logic          ready;
  cpbi_pkg::q16_t t;

  modport source (output valid, output t, input ready);
  modport sink   (input valid, input t, output ready);
endinterface

// ----- rtl/cpbi_out_if.sv -----
// Result channel carrying position, angles and field of view.
// No dependencies.
interface cpbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic [15:0]        pitch;
  logic [15:0]        yaw;
  logic [15:0]        roll;
  logic [15:0]        fov_out;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output pitch, output yaw, output roll, output fov_out, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input pitch, input yaw, input roll, input fov_out, output ready);
endinterface

// ----- rtl/cpbi_ease.sv -----
// Three-stage easing pipeline: saturate t, square and cube, then pick
// the eased parameter s and its complement u. Uses cpbi_pkg and the defines header.
`include "camera_path_bezier_interpolator_defines.svh"

module cpbi_ease (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  cpbi_pkg::q16_t in_t,
  input  logic [1:0]     smoothing,
  output logic           out_valid,
  output cpbi_pkg::q16_t s,
  output cpbi_pkg::q16_t u
);

  logic           v1_r, v2_r, v3_r;
  cpbi_pkg::q16_t t1_r, t2_r, s3_r, u3_r;
  logic [32:0]    sq1_r, sq2_r;
  logic [48:0]    cube2_r;

  cpbi_pkg::q16_t t_sat;
  logic [33:0]    q_in;
  logic [34:0]    q_out;
  logic [50:0]    q_both;
  cpbi_pkg::q16_t e_val;
  cpbi_pkg::q16_t s_nxt;

  assign t_sat = (in_t > cpbi_pkg::ONE_Q16) ? cpbi_pkg::ONE_Q16 : in_t;

  always_comb begin
    q_in   = {1'b0, sq2_r} + 34'd32768;
    q_out  = {1'b0, t2_r, 17'd0} - {2'b00, sq2_r} + 35'd32768;
    q_both = {2'b00, sq2_r, 16'd0} + {1'b0, sq2_r, 17'd0}
           - {1'b0, cube2_r, 1'b0} + 51'h0_0000_8000_0000;
    unique case (smoothing)
      cpbi_pkg::SMOOTH_NONE: e_val = t2_r;
      cpbi_pkg::SMOOTH_IN:   e_val = q_in[32:16];
      cpbi_pkg::SMOOTH_OUT:  e_val = q_out[32:16];
      cpbi_pkg::SMOOTH_BOTH: e_val = q_both[48:32];
    endcase
    s_nxt = (e_val > cpbi_pkg::ONE_Q16) ? cpbi_pkg::ONE_Q16 : e_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r    <= t_sat;
      sq1_r   <= 33'(t_sat * t_sat);
      t2_r    <= t1_r;
      sq2_r   <= sq1_r;
      cube2_r <= 49'(sq1_r * t1_r);
      s3_r    <= s_nxt;
      u3_r    <= cpbi_pkg::ONE_Q16 - s_nxt;
    end
  end

  assign out_valid = v3_r;
  assign s         = s3_r;
  assign u         = u3_r;

  `CPBI_ASSERT_NEXT(a_enter, in_valid && adv, v1_r, "accepted request did not enter stage one")
  `CPBI_ASSERT_NOW(a_s_range, v3_r, (s3_r <= cpbi_pkg::ONE_Q16) && (u3_r == cpbi_pkg::ONE_Q16 - s3_r), "eased parameter out of range")

endmodule

// ----- rtl/camera_path_bezier_interpolator.sv -----
// Camera path interpolator top level: configuration registers, easing,
// Bezier weights, products and final sums. Uses cpbi_pkg, cpbi_ease,
// cpbi_in_if, cpbi_out_if and the defines header.
//
// Usage:
//   in_ch  : requests carrying t (Q1.16, values above 1.0 saturate).
//   out_ch : one result per request: Bezier point x/y/z, pitch/yaw/roll
//            moved along the shorter way round, and fov_out in Q8.8.
//   cfg_*  : write-only registers, written only while no request is in flight (user's duty, not enforced).
// Six register stages lie between an accepted request and its result on
// out_ch. Throughput is one request per cycle while out_ch does not stall;
// the 6-stage pipeline (3 easing stages, weight stage, product stage, sum
// stage) is set by the chained multiplies of t.
// Reset clears all valid bits and returns the registers to their defaults
// (points and angles zero, both fov 90, no smoothing).
// When out_ch.ready is low with a result waiting, the whole pipeline holds
// and in_ch.ready drops; bubbles in flight stay in place until it moves.
`include "camera_path_bezier_interpolator_defines.svh"

module camera_path_bezier_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  cpbi_in_if.sink                             in_ch,
  cpbi_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cpbi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpbi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [47:0] start_point_r, center_point_r, end_point_r;
  logic [47:0] start_angles_r, end_angles_r;
  logic [7:0]  start_fov_r, end_fov_r;
  logic [1:0]  smoothing_r;

  logic           adv;
  logic           v3;
  cpbi_pkg::q16_t s3, u3;

  logic                v4_r, v5_r, v6_r;
  cpbi_pkg::wgt_t      w0_r, w1_r, w2_r;
  logic signed [33:0]  dprod_r [3];
  logic [24:0]         fsum_r;
  logic signed [49:0]  prod_r [3][3];
  logic [15:0]         angle5_r [3];
  logic [15:0]         fov5_r;
  logic [15:0]         point6_r [3];
  logic [15:0]         angle6_r [3];
  logic [15:0]         fov6_r;

  logic [33:0]        su;
  logic [15:0]        dmod [3];
  logic signed [33:0] step_sum [3];
  logic [24:0]        fov_round;
  logic signed [51:0] acc [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_point_r  <= '0;
      center_point_r <= '0;
      end_point_r    <= '0;
      start_angles_r <= '0;
      end_angles_r   <= '0;
      start_fov_r    <= cpbi_pkg::FOV_RESET;
      end_fov_r      <= cpbi_pkg::FOV_RESET;
      smoothing_r    <= cpbi_pkg::SMOOTH_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpbi_pkg::REG_START_POINT:  start_point_r  <= cfg_data[47:0];
        cpbi_pkg::REG_CENTER_POINT: center_point_r <= cfg_data[47:0];
        cpbi_pkg::REG_END_POINT:    end_point_r    <= cfg_data[47:0];
        cpbi_pkg::REG_START_ANGLES: start_angles_r <= cfg_data[47:0];
        cpbi_pkg::REG_END_ANGLES:   end_angles_r   <= cfg_data[47:0];
        cpbi_pkg::REG_START_FOV:    start_fov_r    <= cfg_data[7:0];
        cpbi_pkg::REG_END_FOV:      end_fov_r      <= cfg_data[7:0];
        cpbi_pkg::REG_SMOOTHING:    smoothing_r    <= cfg_data[1:0];
      endcase
    end
  end

  assign adv         = out_ch.ready | ~v6_r;
  assign in_ch.ready = adv;

  cpbi_ease u_ease (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .in_t      (in_ch.t),
    .smoothing (smoothing_r),
    .out_valid (v3),
    .s         (s3),
    .u         (u3)
  );

  always_comb begin
    su        = s3 * u3;
    fov_round = fsum_r + 25'd128;
    for (int i = 0; i < 3; i++) begin
      dmod[i]     = end_angles_r[16*i +: 16] - start_angles_r[16*i +: 16];
      step_sum[i] = dprod_r[i] + 34'sd32768;
      acc[i]      = 52'(prod_r[i][0]) + 52'(prod_r[i][1]) + 52'(prod_r[i][2])
                  + 52'sh0_0000_8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // weights, angle deltas and fov blend
      w0_r   <= 33'(u3 * u3);
      w1_r   <= {su[31:0], 1'b0};
      w2_r   <= 33'(s3 * s3);
      fsum_r <= 25'(start_fov_r * u3) + 25'(end_fov_r * s3);
      for (int i = 0; i < 3; i++) begin
        dprod_r[i] <= 34'($signed(dmod[i]) * $signed({1'b0, s3}));
      end
      // control point products, angle and fov rounding
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= $signed(start_point_r[16*i +: 16])  * $signed({1'b0, w0_r});
        prod_r[i][1] <= $signed(center_point_r[16*i +: 16]) * $signed({1'b0, w1_r});
        prod_r[i][2] <= $signed(end_point_r[16*i +: 16])    * $signed({1'b0, w2_r});
        angle5_r[i]  <= start_angles_r[16*i +: 16] + step_sum[i][31:16];
      end
      fov5_r <= fov_round[23:8];
      // final sums
      for (int i = 0; i < 3; i++) begin
        point6_r[i] <= acc[i][47:32];
        angle6_r[i] <= angle5_r[i];
      end
      fov6_r <= fov5_r;
    end
  end

  assign out_ch.valid   = v6_r;
  assign out_ch.point_x = point6_r[0];
  assign out_ch.point_y = point6_r[1];
  assign out_ch.point_z = point6_r[2];
  assign out_ch.pitch   = angle6_r[0];
  assign out_ch.yaw     = angle6_r[1];
  assign out_ch.roll    = angle6_r[2];
  assign out_ch.fov_out = fov6_r;

  `CPBI_ASSERT_NEXT(a_stall_freeze, !adv, $stable({v3, v4_r, v5_r, v6_r}), "pipeline moved during stall")
  `CPBI_ASSERT_NOW(a_fov_flat, v6_r && (start_fov_r == end_fov_r), fov6_r == {start_fov_r, 8'h00}, "fov blend wrong for equal ends")

endmodule
